/* rtl/proximity_hit_merge_table_top_macros.svh */
// Assertion macros for the proximity hit merge table
`ifndef PROXIMITY_HIT_MERGE_TABLE_TOP_MACROS_SVH
`define PROXIMITY_HIT_MERGE_TABLE_TOP_MACROS_SVH

// assert that a condition implies a consequence in the same cycle
`define PHM_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// assert that a condition implies a consequence in the next cycle
`define PHM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/phm_pkg.sv */
// Package: types, constants and helpers of the proximity hit merge table
`timescale 1ns / 1ps
`default_nettype none
package phm_pkg;
    localparam int MAX_HITS_DEF = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 22;

    localparam logic [CFG_IDX_W-1:0] REG_MERGE_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT   = 1'b1;

    localparam logic [11:0] MERGE_RADIUS_RST = 12'd48;
    localparam logic [21:0] TIME_LIMIT_RST   = 22'd2000000;

    typedef struct packed {
        logic               req_type;
        logic [23:0]        deposit_energy;
        logic [21:0]        deposit_time;
        logic               is_charged;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        element_id;
    } in_word_t;

    typedef struct packed {
        logic               record_kind;
        logic               accepted;
        logic               merged;
        logic [5:0]         slot;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic signed [15:0] hit_z;
        logic [31:0]        hit_energy;
        logic [15:0]        hit_element;
        logic [21:0]        hit_time;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        energy;
        logic [15:0]        element;
        logic [21:0]        tstamp;
    } hit_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic rd_issue;   // read slot at scan index
        logic scan_cmp;   // compare read data
        logic scan_adv;   // advance scan index
        logic commit;     // write merge or new hit
        logic emit_dep;   // build deposit response
        logic emit_rej;   // build reject or empty record
        logic emit_rec;   // build flush record from read data
        logic clear;      // empty the table
    } phm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic reject;
        logic empty;
        logic scan_done;
        logic rec_last;
        logic out_busy;
    } phm_sts_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_CMP    = 8'b0000_1000,
        ST_COMMIT = 8'b0001_0000,
        ST_RESP   = 8'b0010_0000,
        ST_FREAD  = 8'b0100_0000,
        ST_FEMIT  = 8'b1000_0000
    } phm_state_t;
endpackage
`default_nettype wire

/* rtl/proximity_hit_merge_table_top.sv */
// Proximity hit merge table: an accepted deposit scans the stored hits through the single
// read port of the hit memory, one slot per cycle, then commits the merge or new hit and
// emits its response; a rejected deposit or a flush of an empty table is answered from the
// check state, and a flush reads and emits each stored hit in turn. One word is handled at a
// time; the next is taken once the previous result is in the output register, and a stalled
// output holds the block before each emit.
`timescale 1ns / 1ps
`default_nettype none
`include "proximity_hit_merge_table_top_macros.svh"
module proximity_hit_merge_table_top
    import phm_pkg::*;
#(
    parameter int MAX_HITS = MAX_HITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    phm_cmd_t cmd;
    phm_sts_t sts;

    phm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .sts(sts), .cmd(cmd)
    );

    phm_datapath #(.MAX_HITS(MAX_HITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    `PHM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")
    `PHM_ASSERT_IMP(a_one_emit, 1'b1, $countones({cmd.emit_dep, cmd.emit_rej, cmd.emit_rec}) <= 1, "two emits at once")
    `PHM_ASSERT_IMP(a_emit_free, cmd.emit_rej || cmd.emit_dep || cmd.emit_rec, !(out_valid && out_stall) || cmd.emit_dep, "emit onto a stalled output")
endmodule
`default_nettype wire

/* rtl/phm_ctrl.sv */
// Controller state machine of the proximity hit merge table
`timescale 1ns / 1ps
`default_nettype none
module phm_ctrl
    import phm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire phm_sts_t sts,
    output phm_cmd_t      cmd
);
    phm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.out_busy)
                begin
                    if (sts.is_flush)
                    begin
                        if (sts.empty)
                        begin
                            cmd.emit_rej = 1'b1;
                            cmd.clear = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next = ST_FEMIT;
                        end
                    end
                    else if (sts.reject)
                    begin
                        cmd.emit_rej = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (sts.empty)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.scan_adv = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.emit_dep = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FREAD:
            begin
                if (!sts.out_busy)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_FEMIT;
                end
            end
            ST_FEMIT:
            begin
                cmd.emit_rec = 1'b1;
                cmd.scan_adv = 1'b1;
                if (sts.rec_last)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/phm_datapath.sv */
// Datapath of the proximity hit merge table: hit memory, distance compare, output register
`timescale 1ns / 1ps
`default_nettype none
module phm_datapath
    import phm_pkg::*;
#(
    parameter int MAX_HITS = MAX_HITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_word_t              in_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire phm_cmd_t              cmd,
    output phm_sts_t                   sts,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_data
);
    localparam int SW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW = $clog2(MAX_HITS + 1);

    logic [11:0] radius_reg;
    logic [21:0] tlimit_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    in_word_t req_reg;
    hit_t mem [MAX_HITS];
    hit_t rd_reg;
    logic found_reg;
    logic [SW-1:0] fslot_reg;
    logic [23:0] r2_reg;
    logic [SW-1:0] cslot_reg;
    hit_t cdata_reg;
    logic out_valid_reg;
    out_word_t out_reg;

    logic signed [16:0] dx, dy, dz;
    logic [33:0] dx2, dy2, dz2;
    logic [35:0] d2;
    logic [32:0] esum;
    logic [SW-1:0] ridx;
    logic [SW-1:0] raddr;

    assign ridx = idx_reg[SW-1:0];
    // fetch the next slot while the current one is compared
    assign raddr = cmd.scan_adv ? ridx + 1'b1 : ridx;
    assign dx = 17'(req_reg.pos_x) - 17'(rd_reg.x);
    assign dy = 17'(req_reg.pos_y) - 17'(rd_reg.y);
    assign dz = 17'(req_reg.pos_z) - 17'(rd_reg.z);
    assign dx2 = 34'(dx * dx);
    assign dy2 = 34'(dy * dy);
    assign dz2 = 34'(dz * dz);
    assign d2 = 36'(dx2) + 36'(dy2) + 36'(dz2);
    assign esum = 33'(rd_reg.energy) + 33'(req_reg.deposit_energy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= MERGE_RADIUS_RST;
            tlimit_reg <= TIME_LIMIT_RST;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MERGE_RADIUS: radius_reg <= cfg_data[11:0];
                    REG_TIME_LIMIT:   tlimit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_adv)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.scan_cmp && (36'(d2) < 36'(r2_reg)))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && !found_reg)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            if (cmd.emit_dep || cmd.emit_rej || cmd.emit_rec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload and memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
            r2_reg <= 24'(radius_reg) * 24'(radius_reg);
        end
        if (cmd.rd_issue)
        begin
            rd_reg <= mem[raddr];
        end
        if (cmd.scan_cmp && (d2 < 36'(r2_reg)))
        begin
            fslot_reg <= ridx;
            cdata_reg <= '{x: rd_reg.x, y: rd_reg.y, z: rd_reg.z,
                           energy: esum[32] ? 32'hFFFF_FFFF : esum[31:0],
                           element: rd_reg.element, tstamp: rd_reg.tstamp};
        end
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                mem[fslot_reg] <= cdata_reg;
                cslot_reg <= fslot_reg;
            end
            else
            begin
                cdata_reg <= '{x: req_reg.pos_x, y: req_reg.pos_y, z: req_reg.pos_z,
                               energy: 32'(req_reg.deposit_energy),
                               element: req_reg.element_id, tstamp: req_reg.deposit_time};
                mem[count_reg[SW-1:0]] <= '{x: req_reg.pos_x, y: req_reg.pos_y,
                               z: req_reg.pos_z, energy: 32'(req_reg.deposit_energy),
                               element: req_reg.element_id, tstamp: req_reg.deposit_time};
                cslot_reg <= count_reg[SW-1:0];
            end
        end
        if (cmd.emit_rej)
        begin
            out_reg <= '{record_kind: req_reg.req_type, last: 1'b1, default: '0};
        end
        else if (cmd.emit_dep)
        begin
            out_reg <= '{record_kind: 1'b0, accepted: 1'b1, merged: found_reg,
                         slot: 6'(cslot_reg), hit_x: cdata_reg.x, hit_y: cdata_reg.y,
                         hit_z: cdata_reg.z, hit_energy: cdata_reg.energy,
                         hit_element: cdata_reg.element, hit_time: cdata_reg.tstamp,
                         last: 1'b1};
        end
        else if (cmd.emit_rec)
        begin
            out_reg <= '{record_kind: 1'b1, accepted: 1'b1, merged: 1'b0,
                         slot: 6'(ridx), hit_x: rd_reg.x, hit_y: rd_reg.y,
                         hit_z: rd_reg.z, hit_energy: rd_reg.energy,
                         hit_element: rd_reg.element, hit_time: rd_reg.tstamp,
                         last: sts.rec_last};
        end
    end

    always_comb
    begin
        sts.is_flush = req_reg.req_type;
        sts.reject = (req_reg.deposit_energy == 24'd0) || (req_reg.deposit_time > tlimit_reg)
                     || !req_reg.is_charged || (count_reg >= CW'(MAX_HITS));
        sts.empty = (count_reg == '0);
        sts.scan_done = (idx_reg + 1'b1 >= count_reg);
        sts.rec_last = (idx_reg + 1'b1 >= count_reg);
        sts.out_busy = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule
`default_nettype wire
